[design/fca_pkg.sv]
// Shared types and sizing constants for the FIFO capacity admission block.
`default_nettype none
package fca_pkg;

	localparam int QUEUE_DEPTH = 32;   // power of two: pointers wrap naturally
	localparam int HOLD_SLOTS  = 1024; // power of two: slot index wraps naturally
	localparam int QA_W        = $clog2(QUEUE_DEPTH);
	localparam int QC_W        = QA_W + 1;
	localparam int SLOT_W      = $clog2(HOLD_SLOTS);
	localparam int ID_W        = 16;
	localparam int HOLD_W      = 10;
	localparam int UNITS_W     = 16;
	localparam int CAP_W       = 20;
	localparam int OCC_W       = 21;
	localparam int TIME_W      = 32;
	localparam int PADDR_W     = 3;

	localparam logic ACT_ARRIVE = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	typedef struct packed {
		logic               action;
		logic [ID_W-1:0]    request_id;
		logic [HOLD_W-1:0]  hold_ticks;
		logic [UNITS_W-1:0] units;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]   admitted_id;
		logic [TIME_W-1:0] admit_time;
		logic              last;
		logic              queue_overflow;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [HOLD_W-1:0]  hold;
		logic [UNITS_W-1:0] units;
	} qent_t;

endpackage
`default_nettype wire

[design/fifo_capacity_admission.sv]
// Top level of the FIFO capacity admission block: queue, release ring and sequencer.
`default_nettype none
// Usage:
//   req channel (req_valid/req_ready, payload req): action 0 queues an arrival
//   (id, hold, units); action 1 ends the current tick: release the units due
//   now, admit queue heads in order while they fit under capacity_limit, then
//   advance the tick counter.
//   rsp channel (rsp_valid/rsp_ready, payload rsp): one item per admission,
//   last set on the final admission of a tick; an arrival to a full queue
//   gives one item with queue_overflow and last set.
//   APB port: register 0 at address 0 holds capacity_limit; write it only
//   while the block is idle.
// Ring access: every admission does a read-modify-write of the release ring,
//   whose read data is registered: ST_CHK reads the slot of the admitted
//   head and ST_UPD writes the sum back. A tick visits ST_REL, then ST_CHK,
//   and ST_UPD and ST_CHK again for each admission, before it ends.
// Reset: the 1024-entry release ring is swept to zero, one slot a cycle, so
//   req_ready stays low until the sweep ends; APB writes are taken.
// Stall: a result waits in the output register; the sequencer holds while
//   rsp_ready is low and a further result is ready to move.
module fifo_capacity_admission
	import fca_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire req_t               req,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output rsp_t                    rsp,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_OVF  = 3'd1;
	localparam logic [2:0] ST_REL  = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;

	// control state
	logic [2:0]        state_q;
	logic              clr_q;
	logic [SLOT_W-1:0] clr_idx_q;
	logic [QA_W-1:0]   head_q;
	logic [QC_W-1:0]   count_q;
	logic [OCC_W-1:0]  occ_q;
	logic [TIME_W-1:0] time_q;
	logic [CAP_W-1:0]  cap_q;
	logic              pend_valid_q;
	logic              rsp_valid_q;

	// payload registers
	logic [ID_W-1:0]    pend_id_q;
	logic [UNITS_W-1:0] units_q;
	logic [SLOT_W-1:0]  slot_q;
	rsp_t               rsp_q;

	// memories and their registered read data
	qent_t             queue_mem [QUEUE_DEPTH];
	logic [OCC_W-1:0]  ring_mem  [HOLD_SLOTS];
	qent_t             q_rdata_q;
	logic [OCC_W-1:0]  ring_rdata_q;

	logic              q_we;
	logic [QA_W-1:0]   q_waddr;
	logic              q_re;
	logic [QA_W-1:0]   q_raddr;
	logic              ring_we;
	logic [SLOT_W-1:0] ring_waddr;
	logic [OCC_W-1:0]  ring_wdata;
	logic              ring_re;
	logic [SLOT_W-1:0] ring_raddr;

	logic                 req_fire;
	logic                 out_free;
	logic                 q_full;
	logic [SLOT_W-1:0]    now_slot;
	logic [OCC_W:0]       need;
	logic                 admit;
	logic                 push;
	rsp_t                 push_data;
	logic [QA_W-1:0]      tail;

	assign req_ready = (state_q == ST_IDLE) && !clr_q;
	assign req_fire  = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign q_full    = (count_q == QC_W'(QUEUE_DEPTH));
	assign now_slot  = time_q[SLOT_W-1:0];
	assign tail      = head_q + count_q[QA_W-1:0];
	// head fits when occupancy plus its units stays within the limit
	assign need      = {1'b0, occ_q} + (OCC_W+1)'(q_rdata_q.units);
	assign admit     = (count_q != '0) && (need <= (OCC_W+1)'(cap_q));

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// APB: single register, no wait states
	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1] == 1'b0) ? 32'(cap_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (psel && penable && pwrite && (paddr[PADDR_W-1] == 1'b0)) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// memory port control
	always_comb begin
		q_we       = 1'b0;
		q_waddr    = tail;
		q_re       = 1'b0;
		q_raddr    = head_q;
		ring_we    = 1'b0;
		ring_waddr = slot_q;
		ring_wdata = ring_rdata_q + OCC_W'(units_q);
		ring_re    = 1'b0;
		ring_raddr = now_slot;
		push       = 1'b0;
		push_data  = '0;
		if (clr_q) begin
			ring_we    = 1'b1;
			ring_waddr = clr_idx_q;
			ring_wdata = '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire && req.action == ACT_ARRIVE && !q_full) begin
						q_we = 1'b1;
					end
					if (req_fire && req.action == ACT_TICK) begin
						// fetch this tick's releases and the queue head together
						ring_re = 1'b1;
						q_re    = 1'b1;
					end
				end
				ST_OVF: begin
					if (out_free) begin
						push                     = 1'b1;
						push_data.last           = 1'b1;
						push_data.queue_overflow = 1'b1;
					end
				end
				ST_REL: begin
					// drop the slot once its releases are taken
					ring_we    = 1'b1;
					ring_waddr = now_slot;
					ring_wdata = '0;
				end
				ST_CHK: begin
					if (!pend_valid_q || out_free) begin
						push                  = pend_valid_q;
						push_data.admitted_id = pend_id_q;
						push_data.admit_time  = time_q;
						push_data.last        = !admit;
						if (admit) begin
							ring_re    = 1'b1;
							ring_raddr = now_slot + q_rdata_q.hold[SLOT_W-1:0];
						end
					end
				end
				ST_UPD: begin
					// accumulate into the release slot, fetch the next head
					ring_we = 1'b1;
					q_re    = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem[q_waddr] <= '{id: req.request_id, hold: req.hold_ticks,
				units: req.units};
		end
		if (q_re) begin
			q_rdata_q <= queue_mem[q_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_waddr] <= ring_wdata;
		end
		if (ring_re) begin
			ring_rdata_q <= ring_mem[ring_raddr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			clr_q        <= 1'b1;
			clr_idx_q    <= '0;
			head_q       <= '0;
			count_q      <= '0;
			occ_q        <= '0;
			time_q       <= '0;
			pend_valid_q <= 1'b0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == SLOT_W'(HOLD_SLOTS - 1)) begin
				clr_q <= 1'b0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.action == ACT_TICK) begin
							state_q <= ST_REL;
						end else if (q_full) begin
							state_q <= ST_OVF;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				ST_OVF: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_REL: begin
					// release, stopping at zero
					occ_q   <= (ring_rdata_q > occ_q) ? '0 : occ_q - ring_rdata_q;
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (!pend_valid_q || out_free) begin
						if (admit) begin
							pend_valid_q <= 1'b1;
							occ_q        <= need[OCC_W-1:0];
							head_q       <= head_q + 1'b1;
							count_q      <= count_q - 1'b1;
							state_q      <= ST_UPD;
						end else begin
							pend_valid_q <= 1'b0;
							time_q       <= time_q + 1'b1;
							state_q      <= ST_IDLE;
						end
					end
				end
				ST_UPD: begin
					state_q <= ST_CHK;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the admitted head until the next decision tells whether it is last
	always_ff @(posedge clk) begin
		if (!clr_q && state_q == ST_CHK && (!pend_valid_q || out_free) && admit) begin
			pend_id_q <= q_rdata_q.id;
			units_q   <= q_rdata_q.units;
			slot_q    <= now_slot + q_rdata_q.hold[SLOT_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (push) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			rsp_q <= push_data;
		end
	end

endmodule
`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the FIFO capacity admission block.
module tb
	import fca_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// Register map: capacity_limit is register 0, at byte address 0.
	localparam logic [PADDR_W-1:0] REG_CAPACITY = '0;

	localparam int unsigned OCC_MASK       = (1 << OCC_W) - 1;
	localparam int unsigned CAP_MAX        = (1 << CAP_W) - 1;
	// Longest quiet work after the last result: a tick with no admission (IDLE,
	// REL, CHK) or an arrival. Leave a healthy margin on top.
	localparam int          SETTLE_CYCLES  = 16;
	localparam int          HOLDOFF_CYCLES = 400;
	localparam int          PHASES         = 5;
	localparam int          PHASE_ITEMS    = 14;

	// One row of the directed plan. A row may first rewrite capacity_limit
	// (after the block has gone quiet), then offers its item reps times.
	// n_typed < 0: expectations come from the predictor; otherwise the row
	// carries its own expectation (0 or 1 result, given in typed).
	typedef struct {
		bit               set_cap;
		logic [CAP_W-1:0] cap;
		req_t             item;
		int               reps;
		int               n_typed;
		rsp_t             typed;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	req_t               req;
	logic               rsp_valid;
	logic               rsp_ready;
	rsp_t               rsp;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	// Predictor state: its own copy of the queue, ring, occupancy and time.
	qent_t       wait_fifo [QUEUE_DEPTH];
	int unsigned fifo_head;
	int unsigned fifo_count;
	int unsigned release_due [HOLD_SLOTS];
	int unsigned held_units;
	int unsigned tick_count;
	int unsigned cap_limit;

	rsp_t        predicted[$];          // results of the item just accepted
	rsp_t        pending_admissions[$]; // results still owed by the block
	plan_row_t   directed_plan[$];

	bit          no_idle;
	int          holdoff_requests;
	int          failures;
	int          n_items;
	int          n_ticks;
	int          n_overflows;
	int          n_checked;
	int          n_cap_writes;

	fifo_capacity_admission u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// 250 MHz clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run (ring sweep, ~130 items,
	// full 32-result ticks, the long output hold-off and random stalls).
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic rsp_t make_result(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] at,
			input logic last, input logic ovf);
		rsp_t r;
		r.admitted_id    = id;
		r.admit_time     = at;
		r.last           = last;
		r.queue_overflow = ovf;
		return r;
	endfunction

	// Predict the results of one accepted item and advance the predictor state.
	function automatic void predict_item(input req_t it);
		qent_t       head;
		int unsigned now_slot;
		int unsigned slot;
		predicted.delete();
		if (it.action == ACT_ARRIVE) begin
			// A full queue drops the arrival and flags it; otherwise append at the tail.
			if (fifo_count >= QUEUE_DEPTH) begin
				predicted.push_back(make_result('0, '0, 1'b1, 1'b1));
			end else begin
				wait_fifo[(fifo_head + fifo_count) % QUEUE_DEPTH] =
					'{id: it.request_id, hold: it.hold_ticks, units: it.units};
				fifo_count++;
			end
			return;
		end
		// End of tick: return the units due now, floor occupancy at zero.
		now_slot = tick_count % HOLD_SLOTS;
		held_units = (release_due[now_slot] > held_units) ? 0 : held_units - release_due[now_slot];
		release_due[now_slot] = 0;
		// Admit heads in order while they fit; releases on one slot accumulate.
		while (fifo_count > 0) begin
			head = wait_fifo[fifo_head];
			if (held_units + head.units > cap_limit)
				break;
			held_units = (held_units + head.units) & OCC_MASK;
			slot = (now_slot + head.hold % HOLD_SLOTS) % HOLD_SLOTS;
			release_due[slot] = (release_due[slot] + head.units) & OCC_MASK;
			predicted.push_back(make_result(head.id, tick_count, 1'b0, 1'b0));
			fifo_head = (fifo_head + 1) % QUEUE_DEPTH;
			fifo_count--;
		end
		if (predicted.size() != 0)
			predicted[predicted.size() - 1].last = 1'b1;
		tick_count++;
	endfunction

	function automatic void add_plan_row(input bit set_cap, input int unsigned cap, input logic act,
			input int unsigned id, input int unsigned hold, input int unsigned units,
			input int reps, input int n_typed, input rsp_t typed);
		plan_row_t row;
		row.set_cap         = set_cap;
		row.cap             = CAP_W'(cap);
		row.item.action     = act;
		row.item.request_id = ID_W'(id);
		row.item.hold_ticks = HOLD_W'(hold);
		row.item.units      = UNITS_W'(units);
		row.reps            = reps;
		row.n_typed         = n_typed;
		row.typed           = typed;
		directed_plan.push_back(row);
	endfunction

	// Random request shaped by the present capacity: mostly sizes that fit so
	// ticks admit several heads, some full-range sizes that block the queue.
	function automatic req_t random_request(input int unsigned tick_pct);
		req_t        it;
		int unsigned span;
		int unsigned pick;
		it.action     = ($urandom_range(99) < tick_pct) ? ACT_TICK : ACT_ARRIVE;
		it.request_id = ID_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 70)
			it.hold_ticks = HOLD_W'($urandom_range(1, 12));
		else if (pick < 85)
			it.hold_ticks = '0;
		else
			it.hold_ticks = HOLD_W'($urandom);
		span = (cap_limit > 65535) ? 65535 : cap_limit;
		if ($urandom_range(99) < 75)
			it.units = UNITS_W'($urandom_range(0, span / 4));
		else
			it.units = UNITS_W'($urandom);
		return it;
	endfunction

	// Offer one item, with random idle cycles in front; on acceptance, book
	// its expected results.
	task automatic send_item(input req_t it, input int n_typed, input rsp_t typed);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 24) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predict_item(it);
		n_items++;
		if (it.action == ACT_TICK)
			n_ticks++;
		foreach (predicted[i])
			if (predicted[i].queue_overflow)
				n_overflows++;
		if (n_typed < 0) begin
			foreach (predicted[i])
				pending_admissions.push_back(predicted[i]);
		end else if (n_typed > 0) begin
			pending_admissions.push_back(typed);
		end
	endtask

	// Stop offering, wait for every owed result, then let quiet work finish.
	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_admissions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write of capacity_limit, then read it back in a back-to-back transfer.
	task automatic write_capacity(input logic [CAP_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_CAPACITY;
		pwdata  <= 32'(val);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		cap_limit = val;
		n_cap_writes++;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[CAP_W-1:0] !== val) begin
			$error("capacity_limit readback mismatch: expected %0d, got %0d", val,
				prdata[CAP_W-1:0]);
			failures++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Output side: random stalls, none while no_idle is set, and a long
	// hold-off counted here whenever the sequence asks for one.
	initial begin
		int holdoff_left;
		int holdoff_seen;
		holdoff_left = 0;
		holdoff_seen = 0;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_seen != holdoff_requests) begin
				holdoff_seen = holdoff_requests;
				holdoff_left = HOLDOFF_CYCLES;
			end
			if (holdoff_left > 0) begin
				rsp_ready <= 1'b0;
				holdoff_left--;
			end else begin
				rsp_ready <= no_idle || ($urandom_range(99) >= 24);
			end
		end
	end

	// Check every accepted result against the oldest owed one, field by field.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin : check_result
			rsp_t want;
			if (pending_admissions.size() == 0) begin
				$error("unexpected result: id %h time %0d last %b overflow %b",
					rsp.admitted_id, rsp.admit_time, rsp.last, rsp.queue_overflow);
				failures++;
			end else begin
				want = pending_admissions.pop_front();
				n_checked++;
				if (rsp.admitted_id !== want.admitted_id) begin
					$error("admitted_id mismatch: expected %h, got %h",
						want.admitted_id, rsp.admitted_id);
					failures++;
				end
				if (rsp.admit_time !== want.admit_time) begin
					$error("admit_time mismatch: expected %0d, got %0d",
						want.admit_time, rsp.admit_time);
					failures++;
				end
				if (rsp.last !== want.last) begin
					$error("last mismatch: expected %b, got %b", want.last, rsp.last);
					failures++;
				end
				if (rsp.queue_overflow !== want.queue_overflow) begin
					$error("queue_overflow mismatch: expected %b, got %b",
						want.queue_overflow, rsp.queue_overflow);
					failures++;
				end
			end
		end
	end

	initial begin
		int unsigned phase_cap [PHASES];
		int unsigned tick_pct [PHASES];
		// Phases: moderate capacity with a mid-phase sender pause; zero capacity
		// so big heads pile up; full capacity with no idling to flush the queue;
		// moderate capacity under a long output hold-off; a random setting.
		phase_cap = '{1000, 0, CAP_MAX, 5000, 0};
		tick_pct  = '{35, 10, 40, 40, 35};

		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		no_idle   = 1'b0;
		holdoff_requests = 0;
		failures  = 0;
		n_items   = 0;
		n_ticks   = 0;
		n_overflows  = 0;
		n_checked    = 0;
		n_cap_writes = 0;

		// Predictor after reset: empty queue, clear ring, time zero, limit zero.
		fifo_head  = 0;
		fifo_count = 0;
		held_units = 0;
		tick_count = 0;
		cap_limit  = 0;
		foreach (release_due[i])
			release_due[i] = 0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed plan. The first rows are simple enough to type their results.
		// Zero-unit head under a zero limit goes through at time 0.
		add_plan_row(1, 0, ACT_ARRIVE, 'hFFFF, 1, 0, 1, 0, '0);
		add_plan_row(0, 0, ACT_TICK, 0, 0, 0, 1, 1, make_result('hFFFF, 0, 1'b1, 1'b0));
		// One unit with the longest hold waits while the limit is zero.
		add_plan_row(0, 0, ACT_ARRIVE, 'h0000, 1023, 1, 1, 0, '0);
		add_plan_row(0, 0, ACT_TICK, 0, 0, 0, 1, 0, '0);
		// Raise the limit to one: admitted at time 2.
		add_plan_row(1, 1, ACT_TICK, 0, 0, 0, 1, 1, make_result('h0000, 2, 1'b1, 1'b0));
		// Zero hold and zero units fits at the brim; the next head does not.
		add_plan_row(0, 0, ACT_ARRIVE, 'h1234, 0, 0, 1, 0, '0);
		add_plan_row(0, 0, ACT_ARRIVE, 'h5555, 1, 1, 1, 0, '0);
		add_plan_row(0, 0, ACT_TICK, 0, 0, 0, 1, 1, make_result('h1234, 3, 1'b1, 1'b0));
		// Largest limit, largest size: two admissions in one tick.
		add_plan_row(1, CAP_MAX, ACT_ARRIVE, 'hAAAA, 2, 'hFFFF, 1, 0, '0);
		add_plan_row(0, 0, ACT_TICK, 0, 0, 0, 1, -1, '0);
		// Two releases due on the same tick must add up.
		add_plan_row(0, 0, ACT_ARRIVE, 'h0001, 3, 'hFFFF, 1, -1, '0);
		add_plan_row(0, 0, ACT_ARRIVE, 'h0002, 3, 'h8000, 1, -1, '0);
		add_plan_row(0, 0, ACT_TICK, 0, 0, 0, 1, -1, '0);
		add_plan_row(0, 0, ACT_TICK, 0, 0, 0, 3, -1, '0);
		// Lower the limit below what is held: the head waits for the release.
		add_plan_row(0, 0, ACT_ARRIVE, 'h0003, 5, 40000, 1, -1, '0);
		add_plan_row(0, 0, ACT_TICK, 0, 0, 0, 1, -1, '0);
		add_plan_row(1, 100, ACT_ARRIVE, 'h0004, 1, 50, 1, -1, '0);
		add_plan_row(0, 0, ACT_TICK, 0, 0, 0, 6, -1, '0);
		// Fill the queue, overflow once, then drain all 32 heads in one tick.
		add_plan_row(0, 0, ACT_ARRIVE, 'h0F0F, 7, 0, QUEUE_DEPTH + 1, -1, '0);
		add_plan_row(0, 0, ACT_TICK, 0, 0, 0, 1, -1, '0);
		add_plan_row(0, 0, ACT_TICK, 0, 0, 0, 1, -1, '0);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].set_cap) begin
				wait_drained();
				write_capacity(directed_plan[i].cap);
			end
			repeat (directed_plan[i].reps)
				send_item(directed_plan[i].item, directed_plan[i].n_typed,
					directed_plan[i].typed);
		end

		// Random phases; the limit only changes once the block is quiet.
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			write_capacity((p == PHASES - 1) ? CAP_W'($urandom) : CAP_W'(phase_cap[p]));
			no_idle = (p == 2);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// Sender pause: hold off until every owed result is back.
				if (p == 0 && k == PHASE_ITEMS / 2)
					wait_drained();
				// Output hold-off while input keeps coming: the block backs up.
				if (p == 3 && k == 3)
					holdoff_requests++;
				send_item(random_request(tick_pct[p]), -1, '0);
			end
		end
		no_idle = 1'b0;

		wait_drained();
		$display("covered %0d items: %0d ticks, %0d overflow drops, %0d results checked",
			n_items, n_ticks, n_overflows, n_checked);
		$display("%0d capacity writes incl. 0 and %0d, one %0d-cycle output hold-off",
			n_cap_writes, CAP_MAX, HOLDOFF_CYCLES);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
